// ----- design/sud_pkg.sv -----
`timescale 1ns / 1ps

package sud_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [2:0] {
      OP_INS_A  = 3'd0,
      OP_INS_B  = 3'd1,
      OP_UNION  = 3'd2,
      OP_INTER  = 3'd3,
      OP_A_DIFF = 3'd4,
      OP_B_DIFF = 3'd5
   } op_type;

   // response kinds carried on rsp_tuser
   typedef enum logic [2:0] {
      ST_ELEMENT   = 3'd0,
      ST_ADDED     = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INSERT,
      S_WALK,
      S_FINISH
   } state_type;

   localparam int RES_CNT_W = 6;
   localparam logic [RES_CNT_W-1:0] RESULT_LIMIT = 6'd32;

   typedef struct packed {
      logic        last;
      status_type  status;
      logic [31:0] element;
   } rsp_type;

endpackage

// ----- design/sud_store.sv -----
`timescale 1ns / 1ps

module sud_store #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [31:0]   rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [31:0]   wr_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sud_ctrl.sv -----
`timescale 1ns / 1ps

module sud_ctrl #(
   parameter int SET_DEPTH = 16,
   parameter int IW        = 4,
   parameter int CW        = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [2:0]      req_op,
   input  logic [31:0]     req_value,
   output logic            rd_en,
   output logic [IW-1:0]   rd_addr,
   input  logic [31:0]     rd_data_a,
   input  logic [31:0]     rd_data_b,
   output logic            wr_a_en,
   output logic            wr_b_en,
   output logic [IW-1:0]   wr_addr,
   output logic [31:0]     wr_data,
   input  logic            rsp_free,
   output logic            rsp_load,
   output sud_pkg::rsp_type rsp_word
);

   import sud_pkg::*;

   state_type            state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [31:0]          value_ff, value_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic                 phase_ff, phase_in;
   logic                 dup_ff, dup_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic [CW-1:0]        cnt_a_ff, cnt_a_in;
   logic [CW-1:0]        cnt_b_ff, cnt_b_in;
   logic                 a_in_b_ff [SET_DEPTH];
   logic                 a_in_b_in [SET_DEPTH];
   logic                 b_in_a_ff [SET_DEPTH];
   logic                 b_in_a_in [SET_DEPTH];
   logic                 pend_valid_ff, pend_valid_in;
   logic [31:0]          pend_ff, pend_in;
   logic [RES_CNT_W-1:0] nres_ff, nres_in;

   logic          own_is_b;
   logic [CW-1:0] own_cnt;
   logic [CW-1:0] max_cnt;
   logic [CW-1:0] cur_next;
   logic          match_a;
   logic          match_b;
   logic          scan_end;
   logic          ins_full;
   status_type    ins_status;
   logic          src_is_b;
   logic [CW-1:0] src_cnt;
   logic [31:0]   src_data;
   logic          src_flag;
   logic          sel;
   logic          can_go;
   logic          walk_limit;
   logic          walk_end;
   logic          walk_to_b;

   assign own_is_b  = (op_ff == OP_INS_B);
   assign own_cnt   = own_is_b ? cnt_b_ff : cnt_a_ff;
   assign max_cnt   = (cnt_a_ff > cnt_b_ff) ? cnt_a_ff : cnt_b_ff;
   assign cur_next  = cur_ff + CW'(1);
   assign match_a   = (cur_ff < cnt_a_ff) && (rd_data_a == value_ff);
   assign match_b   = (cur_ff < cnt_b_ff) && (rd_data_b == value_ff);
   assign scan_end  = (cur_next >= max_cnt);
   assign ins_full  = (own_cnt == CW'(SET_DEPTH));
   assign ins_status = dup_ff ? ST_DUPLICATE : (ins_full ? ST_FULL : ST_ADDED);

   assign src_is_b  = (op_ff == OP_B_DIFF) || phase_ff;
   assign src_cnt   = src_is_b ? cnt_b_ff : cnt_a_ff;
   assign src_data  = src_is_b ? rd_data_b : rd_data_a;
   assign src_flag  = src_is_b ? b_in_a_ff[cur_ff[IW-1:0]] : a_in_b_ff[cur_ff[IW-1:0]];

   always_comb begin
      case (op_ff)
         OP_UNION:             sel = phase_ff ? !src_flag : 1'b1;
         OP_INTER:             sel = src_flag;
         OP_A_DIFF, OP_B_DIFF: sel = !src_flag;
         default:              sel = 1'b0;
      endcase
   end

   assign can_go     = !sel || !pend_valid_ff || rsp_free;
   assign walk_limit = sel && ((nres_ff + RES_CNT_W'(1)) == RESULT_LIMIT);
   assign walk_end   = (cur_next == src_cnt);
   assign walk_to_b  = (op_ff == OP_UNION) && !phase_ff && (cnt_b_ff != '0);

   assign req_ready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_INS_A, OP_INS_B:
                     state_in = (max_cnt == '0) ? S_INSERT : S_SCAN;
                  OP_UNION:
                     state_in = (cnt_a_ff != '0 || cnt_b_ff != '0) ? S_WALK : S_FINISH;
                  OP_INTER, OP_A_DIFF:
                     state_in = (cnt_a_ff != '0) ? S_WALK : S_FINISH;
                  OP_B_DIFF:
                     state_in = (cnt_b_ff != '0) ? S_WALK : S_FINISH;
                  default:
                     state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (can_go && (walk_limit || (walk_end && !walk_to_b))) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      phase_in      = phase_ff;
      dup_in        = dup_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      a_in_b_in     = a_in_b_ff;
      b_in_a_in     = b_in_a_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      nres_in       = nres_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_next[IW-1:0];
      wr_a_en       = 1'b0;
      wr_b_en       = 1'b0;
      wr_addr       = own_cnt[IW-1:0];
      wr_data       = value_ff;
      rsp_load      = 1'b0;
      rsp_word      = '{last: 1'b1, status: ST_EMPTY, element: 32'd0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               value_in      = req_value;
               cur_in        = '0;
               dup_in        = 1'b0;
               hit_in        = 1'b0;
               pend_valid_in = 1'b0;
               nres_in       = '0;
               phase_in      = (req_op == OP_UNION) && (cnt_a_ff == '0);
               rd_en         = 1'b1;
               rd_addr       = '0;
            end
         end
         S_SCAN: begin
            // own set gives the duplicate, the other set the cross index
            if (own_is_b) begin
               dup_in = dup_ff | match_b;
               if (match_a) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cur_ff[IW-1:0];
               end
            end else begin
               dup_in = dup_ff | match_a;
               if (match_b) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cur_ff[IW-1:0];
               end
            end
            if (!scan_end) begin
               cur_in = cur_next;
               rd_en  = 1'b1;
            end
         end
         S_INSERT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_word = '{last: 1'b1, status: ins_status, element: value_ff};
               if (ins_status == ST_ADDED) begin
                  if (own_is_b) begin
                     wr_b_en  = 1'b1;
                     cnt_b_in = cnt_b_ff + CW'(1);
                     b_in_a_in[own_cnt[IW-1:0]] = hit_ff;
                     if (hit_ff) begin
                        a_in_b_in[hit_idx_ff] = 1'b1;
                     end
                  end else begin
                     wr_a_en  = 1'b1;
                     cnt_a_in = cnt_a_ff + CW'(1);
                     a_in_b_in[own_cnt[IW-1:0]] = hit_ff;
                     if (hit_ff) begin
                        b_in_a_in[hit_idx_ff] = 1'b1;
                     end
                  end
               end
            end
         end
         S_WALK: begin
            // one selected word is held back until the next one shows whether it is last
            if (can_go) begin
               if (sel) begin
                  if (pend_valid_ff) begin
                     rsp_load = 1'b1;
                     rsp_word = '{last: 1'b0, status: ST_ELEMENT, element: pend_ff};
                  end
                  pend_in       = src_data;
                  pend_valid_in = 1'b1;
                  nres_in       = nres_ff + RES_CNT_W'(1);
               end
               if (!walk_limit) begin
                  if (walk_end) begin
                     if (walk_to_b) begin
                        phase_in = 1'b1;
                        cur_in   = '0;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                     end
                  end else begin
                     cur_in = cur_next;
                     rd_en  = 1'b1;
                  end
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (pend_valid_ff) begin
                  rsp_word = '{last: 1'b1, status: ST_ELEMENT, element: pend_ff};
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < SET_DEPTH; i++) begin
            a_in_b_ff[i] <= 1'b0;
            b_in_a_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         pend_valid_ff <= pend_valid_in;
         a_in_b_ff     <= a_in_b_in;
         b_in_a_ff     <= b_in_a_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      cur_ff     <= cur_in;
      phase_ff   <= phase_in;
      dup_ff     <= dup_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      pend_ff    <= pend_in;
      nres_ff    <= nres_in;
   end

endmodule

// ----- design/two_set_union_intersect_diff.sv -----
// insert: scans both sets together, one stored word of each set read per cycle
// query: one stored word per cycle from one memory port, unless the output stalls the walk
// one request at a time; req_tready is high only between requests
// output words wait in a one-word register; a stall holds the walk in place
// synchronous active-high reset empties both sets; entry memories are not cleared
`timescale 1ns / 1ps

module two_set_union_intersect_diff #(
   parameter int SET_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] op
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] element
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);

   import sud_pkg::*;

   // index bits for the entry memories, count bits wide enough for a full set
   localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CW = $clog2(SET_DEPTH + 1);

   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [31:0]   rd_data_a;
   logic [31:0]   rd_data_b;
   logic          wr_a_en;
   logic          wr_b_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          rsp_free;
   logic          rsp_load;
   rsp_type       rsp_word;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_word_ff, rsp_word_in;

   // set a entries, in insertion order
   sud_store #(
      .DEPTH (SET_DEPTH),
      .IW    (IW)
   ) u_store_a (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // set b entries, read at the same address as set a
   sud_store #(
      .DEPTH (SET_DEPTH),
      .IW    (IW)
   ) u_store_b (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // sequencer: duplicate scan, append, walks and membership flags
   sud_ctrl #(
      .SET_DEPTH (SET_DEPTH),
      .IW        (IW),
      .CW        (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_value (req_tdata),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_a_en   (wr_a_en),
      .wr_b_en   (wr_b_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_free  (rsp_free),
      .rsp_load  (rsp_load),
      .rsp_word  (rsp_word)
   );

   // output register: free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = rsp_word;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff.element;
   assign rsp_tuser  = rsp_word_ff.status;
   assign rsp_tlast  = rsp_word_ff.last;

endmodule

// ----- sim/two_set_union_intersect_diff_tb.sv -----
`timescale 1ns / 1ps

module two_set_union_intersect_diff_tb;
   import sud_pkg::*;

   localparam int SET_DEPTH = 16;

   // op codes the block has no use for; they must leave the sets alone and give no word
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // receiver stall patterns; the receiver switches to a randomly picked one at regular intervals
   localparam int RX_ALWAYS  = 0;
   localparam int RX_MOSTLY  = 1;
   localparam int RX_SPARSE  = 2;
   localparam int RX_TOGGLE  = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [2:0]  req_tuser = '0;   // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] element
   logic [2:0]  rsp_tuser;        // [2:0] status
   logic        rsp_tlast;

   // keeps its own copy of both sets and the answer words still owed by the block
   class set_op_scoreboard;
      logic [31:0] set_a[$];
      logic [31:0] set_b[$];
      rsp_type     answer[$];
      rsp_type     awaited[$];
      int unsigned errors = 0;

      function bit is_member(logic [31:0] store[$], logic [31:0] v);
         foreach (store[i])
            if (store[i] == v)
               return 1'b1;
         return 1'b0;
      endfunction

      // answers are capped, anything past the cap is dropped
      function void add_word(status_type st, logic [31:0] elem);
         rsp_type w;
         if (answer.size() >= int'(RESULT_LIMIT))
            return;
         w.status  = st;
         w.element = elem;
         w.last    = 1'b0;
         answer.push_back(w);
      endfunction

      // every entry of src whose membership in other matches want_in, in src order
      function void collect(logic [31:0] src[$], logic [31:0] other[$], bit want_in);
         foreach (src[i])
            if (is_member(other, src[i]) == want_in)
               add_word(ST_ELEMENT, src[i]);
      endfunction

      function status_type insert_status(logic [31:0] store[$], logic [31:0] v);
         // a value already present counts as duplicate even when the set is full
         if (is_member(store, v))
            return ST_DUPLICATE;
         else if (store.size() >= SET_DEPTH)
            return ST_FULL;
         return ST_ADDED;
      endfunction

      function void note_request(logic [2:0] op, logic [31:0] value);
         status_type st;
         answer.delete();
         case (op)
            OP_INS_A: begin
               st = insert_status(set_a, value);
               if (st == ST_ADDED)
                  set_a.push_back(value);
               add_word(st, value);
            end
            OP_INS_B: begin
               st = insert_status(set_b, value);
               if (st == ST_ADDED)
                  set_b.push_back(value);
               add_word(st, value);
            end
            OP_UNION: begin
               foreach (set_a[i])
                  add_word(ST_ELEMENT, set_a[i]);
               collect(set_b, set_a, 1'b0);
            end
            OP_INTER:  collect(set_a, set_b, 1'b1);
            OP_A_DIFF: collect(set_a, set_b, 1'b0);
            OP_B_DIFF: collect(set_b, set_a, 1'b0);
            default:   return;
         endcase
         if (answer.size() == 0)
            add_word(ST_EMPTY, 32'd0);
         answer[answer.size() - 1].last = 1'b1;
         foreach (answer[i])
            awaited.push_back(answer[i]);
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function void check_result(logic [2:0] status, logic [31:0] element, logic last);
         rsp_type w;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected word, status %0d element %0h last %0b",
                     $time, status, element, last);
            errors++;
            return;
         end
         w = awaited.pop_front();
         if (w.status != status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, w.status, status);
            errors++;
         end
         if (w.element != element) begin
            $display("%0t: element mismatch, expected %0h actual %0h",
                     $time, w.element, element);
            errors++;
         end
         if (w.last != last) begin
            $display("%0t: last mismatch, expected %0b actual %0b", $time, w.last, last);
            errors++;
         end
      endfunction
   endclass

   set_op_scoreboard board = new();

   two_set_union_intersect_diff #(
      .SET_DEPTH(SET_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // sender burst bookkeeping
   int unsigned burst_left = 0;

   // offers one word, with a random gap when the current burst runs out;
   // returns at the edge where the word was taken, valid still high
   task automatic send_item(input logic [2:0] op, input logic [31:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         // about a quarter of bursts follow straight on with no gap at all
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      board.note_request(op, value);
   endtask

   // a value for an insert: often one held by the other set so that the
   // intersection and differences have something to show, sometimes a repeat
   function automatic logic [31:0] pick_value(bit into_b);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel <= 2 && !into_b && board.set_b.size() > 0)
         return board.set_b[$urandom_range(0, board.set_b.size() - 1)];
      if (sel <= 2 && into_b && board.set_a.size() > 0)
         return board.set_a[$urandom_range(0, board.set_a.size() - 1)];
      if (sel == 3 && !into_b && board.set_a.size() > 0)
         return board.set_a[$urandom_range(0, board.set_a.size() - 1)];
      if (sel == 3 && into_b && board.set_b.size() > 0)
         return board.set_b[$urandom_range(0, board.set_b.size() - 1)];
      if (sel <= 5)
         return 32'($signed($urandom_range(0, 8)) - 4);
      return $urandom();
   endfunction

   // receiver: takes words, checks them, and stalls on a pattern of its own;
   // once, after a fair number of words, it holds off for a long stretch so
   // that the block fills up and stops taking requests
   int unsigned words_taken = 0;
   int unsigned hold_left   = 0;
   int unsigned mode_cycles = 0;
   int          rx_mode     = RX_ALWAYS;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
            words_taken++;
            if (words_taken == 80)
               hold_left = 300;
         end
         mode_cycles++;
         if (mode_cycles >= 50) begin
            mode_cycles = 0;
            rx_mode     = $urandom_range(RX_ALWAYS, RX_TOGGLE);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   initial begin
      int unsigned done;
      int unsigned pick;
      int unsigned tries;
      bit          into_b;
      logic [2:0]  op;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // queries on two empty sets each give a single empty-answer word
      send_item(OP_UNION, 32'd0);
      send_item(OP_INTER, 32'hffff_ffff);
      send_item(OP_A_DIFF, 32'd0);
      send_item(OP_B_DIFF, 32'd0);
      // spare op codes do nothing
      send_item(OP_SPARE_6, 32'h1234_5678);
      send_item(OP_SPARE_7, 32'hffff_ffff);
      // extremes of the value into A, then a repeat
      send_item(OP_INS_A, 32'h8000_0000);
      send_item(OP_INS_A, 32'h7fff_ffff);
      send_item(OP_INS_A, 32'd0);
      send_item(OP_INS_A, 32'h8000_0000);
      // B overlaps A in two values
      send_item(OP_INS_B, 32'hffff_ffff);
      send_item(OP_INS_B, 32'h7fff_ffff);
      send_item(OP_INS_B, 32'd0);
      send_item(OP_INS_B, 32'hffff_ffff);
      send_item(OP_UNION, 32'd0);
      send_item(OP_INTER, 32'd0);
      send_item(OP_A_DIFF, 32'd0);
      send_item(OP_B_DIFF, 32'd0);

      // random part: a mix of inserts and queries, spare codes now and then
      done = 0;
      while (done < 165) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_item(($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7, $urandom());
         end else begin
            if (pick < 38) begin
               into_b = $urandom_range(0, 1);
               op     = into_b ? OP_INS_B : OP_INS_A;
               send_item(op, pick_value(into_b));
            end else begin
               op = 3'($urandom_range(OP_UNION, OP_B_DIFF));
               send_item(op, $urandom());
            end
            done++;
         end
         // once midway the sender waits until every owed word has come
         if (done == 80 && pick >= 4) begin
            req_tvalid <= 1'b0;
            while (board.outstanding() != 0)
               @(posedge clock);
            burst_left = 0;
         end
      end

      // fill both sets to the brim, then a new value, a repeat, and all queries
      tries = 0;
      while (board.set_a.size() < SET_DEPTH && tries < 200) begin
         send_item(OP_INS_A, $urandom());
         tries++;
      end
      tries = 0;
      while (board.set_b.size() < SET_DEPTH && tries < 200) begin
         send_item(OP_INS_B, (tries % 2 == 0) ? board.set_a[tries % SET_DEPTH] : $urandom());
         tries++;
      end
      send_item(OP_INS_A, $urandom());
      send_item(OP_INS_B, $urandom());
      send_item(OP_INS_A, board.set_a[0]);
      send_item(OP_INS_B, board.set_b[SET_DEPTH - 1]);
      send_item(OP_UNION, 32'd0);
      send_item(OP_INTER, 32'd0);
      send_item(OP_A_DIFF, 32'd0);
      send_item(OP_B_DIFF, 32'd0);

      req_tvalid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
      // room for a stray word to turn up after the last one owed
      repeat (50) @(posedge clock);
      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

endmodule
